/* hdl/bvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// bvrgb_pkg
// Shared widths, segment tables and types for the B-V index to RGB converter.
// ----------------------------------------------------------------------------
package bvrgb_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int RECIP_BITS = 16;
  localparam int IDX_W      = 16;
  localparam int OUT_W      = 13;

  // Working width of the index: wide enough for the clamp bounds at any FRAC_BITS.
  localparam int BV_W   = (FRAC_BITS + 4 > IDX_W) ? FRAC_BITS + 4 : IDX_W;
  localparam int D_W    = FRAC_BITS + 1;
  localparam int RCP_W  = RECIP_BITS + 2;
  localparam int C_W    = FRAC_BITS + 2;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int P_W    = D_W + RCP_W;
  localparam int TT_W   = 2 * T_W;
  localparam int C1T_W  = C_W + T_W + 1;
  localparam int C2TT_W = C_W + TT_W + 1;
  localparam int S_W    = C2TT_W + 1;
  localparam int R_W    = S_W - 2 * FRAC_BITS;

  localparam int NCH  = 3;
  localparam int NSTG = 5;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam int STG_SEL = 0;
  localparam int STG_MUL = 1;
  localparam int STG_SQR = 2;
  localparam int STG_C2  = 3;
  localparam int STG_OUT = 4;

  // Coefficients and bounds of one segment.
  typedef struct packed {
    logic signed [BV_W-1:0] start;
    logic [RCP_W-1:0]       rcp;
    logic signed [C_W-1:0]  c0;
    logic signed [C_W-1:0]  c1;
    logic signed [C_W-1:0]  c2;
  } bvrgb_coef_t;

  // Selected segment of one channel, as handed to the polynomial pipe.
  typedef struct packed {
    logic [D_W-1:0]        d;
    logic [RCP_W-1:0]      rcp;
    logic signed [C_W-1:0] c0;
    logic signed [C_W-1:0] c1;
    logic signed [C_W-1:0] c2;
  } bvrgb_seg_t;

  typedef struct packed {
    logic [NSTG-1:0] load;
  } bvrgb_ctl_t;

  // Hundredths to signed fixed point, rounded on the magnitude.
  function automatic int hq(input int k);
    int m;
    int v;
    m = (k < 0) ? -k : k;
    v = ((m << FRAC_BITS) + 50) / 100;
    return (k < 0) ? -v : v;
  endfunction

  function automatic bvrgb_coef_t coef(input int start, input int rcp,
                                       input int c0, input int c1, input int c2);
    bvrgb_coef_t c;
    c.start = BV_W'(start);
    c.rcp   = RCP_W'(rcp);
    c.c0    = C_W'(c0);
    c.c1    = C_W'(c1);
    c.c2    = C_W'(c2);
    return c;
  endfunction

  function automatic bvrgb_seg_t seg_from(input logic signed [BV_W-1:0] bv,
                                          input bvrgb_coef_t c);
    bvrgb_seg_t s;
    logic signed [BV_W-1:0] diff;
    diff  = bv - c.start;
    s.d   = diff[D_W-1:0];
    s.rcp = c.rcp;
    s.c0  = c.c0;
    s.c1  = c.c1;
    s.c2  = c.c2;
    return s;
  endfunction

  localparam int RCP_40  = ((100 << RECIP_BITS) + 40 / 2) / 40;
  localparam int RCP_44  = ((100 << RECIP_BITS) + 44 / 2) / 44;
  localparam int RCP_110 = ((100 << RECIP_BITS) + 110 / 2) / 110;
  localparam int RCP_120 = ((100 << RECIP_BITS) + 120 / 2) / 120;

  localparam logic signed [BV_W-1:0] BV_LO  = BV_W'(hq(-40));
  localparam logic signed [BV_W-1:0] BV_0   = BV_W'(0);
  localparam logic signed [BV_W-1:0] BV_40  = BV_W'(hq(40));
  localparam logic signed [BV_W-1:0] BV_150 = BV_W'(hq(150));
  localparam logic signed [BV_W-1:0] BV_160 = BV_W'(hq(160));
  localparam logic signed [BV_W-1:0] BV_194 = BV_W'(hq(194));
  localparam logic signed [BV_W-1:0] BV_HI  = BV_W'(hq(200));

  localparam bvrgb_coef_t SEG_ONE  = coef(0, 0, hq(100), 0, 0);
  localparam bvrgb_coef_t SEG_ZERO = coef(0, 0, 0, 0, 0);

  localparam bvrgb_coef_t SEG_R0 = coef(hq(-40), RCP_40, hq(61), hq(11), hq(10));
  localparam bvrgb_coef_t SEG_R1 = coef(0, RCP_40, hq(83), hq(17), 0);

  localparam bvrgb_coef_t SEG_G0 = coef(hq(-40), RCP_40, hq(70), hq(7), hq(10));
  localparam bvrgb_coef_t SEG_G1 = coef(0, RCP_40, hq(87), hq(11), 0);
  localparam bvrgb_coef_t SEG_G2 = coef(hq(40), RCP_120, hq(98), hq(-16), 0);
  localparam bvrgb_coef_t SEG_G3 = coef(hq(160), RCP_40, hq(82), 0, hq(-50));

  localparam bvrgb_coef_t SEG_B1 = coef(hq(40), RCP_110, hq(100), hq(-47), hq(10));
  localparam bvrgb_coef_t SEG_B2 = coef(hq(150), RCP_44, hq(63), 0, hq(-60));

endpackage

/* hdl/bvrgb_in_if.sv */
// ----------------------------------------------------------------------------
// bvrgb_in_if
// Input channel: one B-V color index word per handshake.
// ----------------------------------------------------------------------------
interface bvrgb_in_if;
  import bvrgb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [IDX_W-1:0] color_index;

  modport source (output valid, output color_index, input ready);
  modport sink   (input valid, input color_index, output ready);
endinterface

/* hdl/bvrgb_out_if.sv */
// ----------------------------------------------------------------------------
// bvrgb_out_if
// Result channel: red, green and blue levels, one word per handshake.
// ----------------------------------------------------------------------------
interface bvrgb_out_if;
  import bvrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_level;
  logic [OUT_W-1:0] green_level;
  logic [OUT_W-1:0] blue_level;

  modport source (output valid, output red_level, output green_level,
                  output blue_level, input ready);
  modport sink   (input valid, input red_level, input green_level,
                  input blue_level, output ready);
endinterface

/* hdl/bvrgb_seg_sel.sv */
// ----------------------------------------------------------------------------
// bvrgb_seg_sel
// First pipeline stage: clamps the index and picks each channel's segment.
// ----------------------------------------------------------------------------
module bvrgb_seg_sel (
  input  logic                                     clk,
  input  logic                                     load,
  input  logic signed [bvrgb_pkg::IDX_W-1:0]       color_index,
  output bvrgb_pkg::bvrgb_seg_t [bvrgb_pkg::NCH-1:0] seg_r
);
  import bvrgb_pkg::*;

  logic signed [BV_W-1:0]  bv_ext;
  logic signed [BV_W-1:0]  bv_c;
  bvrgb_seg_t [NCH-1:0]    seg_nxt;

  always_comb begin
    bv_ext = BV_W'(color_index);
    if (bv_ext < BV_LO) begin
      bv_c = BV_LO;
    end else if (bv_ext > BV_HI) begin
      bv_c = BV_HI;
    end else begin
      bv_c = bv_ext;
    end

    // Constant segments carry a zero reciprocal, so their position is zero.
    if (bv_c < BV_0) begin
      seg_nxt[CH_RED] = seg_from(bv_c, SEG_R0);
    end else if (bv_c < BV_40) begin
      seg_nxt[CH_RED] = seg_from(bv_c, SEG_R1);
    end else begin
      seg_nxt[CH_RED] = seg_from(bv_c, SEG_ONE);
    end

    if (bv_c < BV_0) begin
      seg_nxt[CH_GREEN] = seg_from(bv_c, SEG_G0);
    end else if (bv_c < BV_40) begin
      seg_nxt[CH_GREEN] = seg_from(bv_c, SEG_G1);
    end else if (bv_c < BV_160) begin
      seg_nxt[CH_GREEN] = seg_from(bv_c, SEG_G2);
    end else if (bv_c < BV_HI) begin
      seg_nxt[CH_GREEN] = seg_from(bv_c, SEG_G3);
    end else begin
      seg_nxt[CH_GREEN] = seg_from(bv_c, SEG_ZERO);
    end

    if (bv_c < BV_40) begin
      seg_nxt[CH_BLUE] = seg_from(bv_c, SEG_ONE);
    end else if (bv_c < BV_150) begin
      seg_nxt[CH_BLUE] = seg_from(bv_c, SEG_B1);
    end else if (bv_c < BV_194) begin
      seg_nxt[CH_BLUE] = seg_from(bv_c, SEG_B2);
    end else begin
      seg_nxt[CH_BLUE] = seg_from(bv_c, SEG_ZERO);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_r <= seg_nxt;
    end
  end

endmodule

/* hdl/bvrgb_chan.sv */
// ----------------------------------------------------------------------------
// bvrgb_chan
// Four-stage polynomial pipe for one channel: position, square, scale, round.
// ----------------------------------------------------------------------------
module bvrgb_chan (
  input  logic                          clk,
  input  bvrgb_pkg::bvrgb_ctl_t         ctl,
  input  bvrgb_pkg::bvrgb_seg_t         seg,
  output logic [bvrgb_pkg::OUT_W-1:0]   level_r
);
  import bvrgb_pkg::*;

  localparam logic [P_W:0]          T_HALF = (P_W + 1)'(1) << (RECIP_BITS - 1);
  localparam logic signed [S_W-1:0] S_HALF = S_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic [R_W-1:0]        R_ONE  = R_W'(1) << FRAC_BITS;

  // Stage: reciprocal product
  logic [P_W-1:0]          prod_r;
  logic [P_W-1:0]          prod_nxt;
  logic signed [C_W-1:0]   c0_1_r;
  logic signed [C_W-1:0]   c1_1_r;
  logic signed [C_W-1:0]   c2_1_r;

  // Stage: t squared and c1 * t
  logic [P_W:0]             t_sum;
  logic [T_W-1:0]           t;
  logic [TT_W-1:0]          tt_r;
  logic [TT_W-1:0]          tt_nxt;
  logic signed [C1T_W-1:0]  c1t_r;
  logic signed [C1T_W-1:0]  c1t_nxt;
  logic signed [C_W-1:0]    c0_2_r;
  logic signed [C_W-1:0]    c2_2_r;

  // Stage: c2 * t * t and the linear part
  logic signed [C2TT_W-1:0] c2tt_r;
  logic signed [C2TT_W-1:0] c2tt_nxt;
  logic signed [S_W-1:0]    base_r;
  logic signed [S_W-1:0]    base_nxt;

  // Stage: round and limit
  logic signed [S_W-1:0]    sum;
  logic signed [S_W-1:0]    rnd_sum;
  logic [R_W-1:0]           rnd;
  logic [R_W-1:0]           lvl;
  logic [OUT_W-1:0]         level_nxt;

  always_comb begin
    prod_nxt = P_W'(seg.d) * P_W'(seg.rcp);

    t_sum   = {1'b0, prod_r} + T_HALF;
    t       = t_sum[RECIP_BITS +: T_W];
    tt_nxt  = TT_W'(t) * TT_W'(t);
    c1t_nxt = C1T_W'(c1_1_r) * $signed(C1T_W'(t));

    c2tt_nxt = C2TT_W'(c2_2_r) * $signed(C2TT_W'(tt_r));
    base_nxt = (S_W'(c0_2_r) <<< (2 * FRAC_BITS)) + (S_W'(c1t_r) <<< FRAC_BITS);

    sum     = base_r + S_W'(c2tt_r);
    rnd_sum = sum + S_HALF;
    rnd     = rnd_sum[2 * FRAC_BITS +: R_W];
    if (sum <= S_W'(0)) begin
      lvl = '0;
    end else if (rnd > R_ONE) begin
      lvl = R_ONE;
    end else begin
      lvl = rnd;
    end
    level_nxt = lvl[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_MUL]) begin
      prod_r <= prod_nxt;
      c0_1_r <= seg.c0;
      c1_1_r <= seg.c1;
      c2_1_r <= seg.c2;
    end
    if (ctl.load[STG_SQR]) begin
      tt_r   <= tt_nxt;
      c1t_r  <= c1t_nxt;
      c0_2_r <= c0_1_r;
      c2_2_r <= c2_1_r;
    end
    if (ctl.load[STG_C2]) begin
      c2tt_r <= c2tt_nxt;
      base_r <= base_nxt;
    end
    if (ctl.load[STG_OUT]) begin
      level_r <= level_nxt;
    end
  end

endmodule

/* hdl/bv_index_to_rgb_core.sv */
// ----------------------------------------------------------------------------
// bv_index_to_rgb_core
// B-V color index to red, green and blue levels, five-stage pipeline.
//
//   Channel   Dir   Payload                                 Word
//   in_ch     in    color_index (s16, 12 fraction bits)     one index
//   out_ch    out   red/green/blue_level (u13, 4096 = 1.0)  one color
//
// One word enters per cycle unless every stage is full and the output is stalled.
// The stages are segment select, reciprocal multiply, square and linear term,
// quadratic term, then sum, round and limit; the multipliers set the depth.
// Reset clears the stage valid bits only; data registers are not reset.
// Each stage holds while the next one is full and stalled, so bubbles close
// up and input is still taken while a finished word waits at the output.
// ----------------------------------------------------------------------------
module bv_index_to_rgb_core (
  input  logic        clk,
  input  logic        rst_n,
  bvrgb_in_if.sink    in_ch,
  bvrgb_out_if.source out_ch
);
  import bvrgb_pkg::*;

  logic [NSTG-1:0]      vld_r;
  logic [NSTG-1:0]      vld_nxt;
  logic [NSTG-1:0]      rdy;
  bvrgb_ctl_t           ctl;
  bvrgb_seg_t [NCH-1:0] seg_r;
  logic                 in_fire;
  logic                 out_fire;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end

    ctl.load[0] = rdy[0] && in_ch.valid;
    vld_nxt[0]  = rdy[0] ? in_ch.valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      ctl.load[i] = rdy[i] && vld_r[i-1];
      vld_nxt[i]  = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld_r[NSTG-1];
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;

  bvrgb_seg_sel u_sel (
    .clk         (clk),
    .load        (ctl.load[STG_SEL]),
    .color_index (in_ch.color_index),
    .seg_r       (seg_r)
  );

  bvrgb_chan u_red (
    .clk     (clk),
    .ctl     (ctl),
    .seg     (seg_r[CH_RED]),
    .level_r (out_ch.red_level)
  );

  bvrgb_chan u_green (
    .clk     (clk),
    .ctl     (ctl),
    .seg     (seg_r[CH_GREEN]),
    .level_r (out_ch.green_level)
  );

  bvrgb_chan u_blue (
    .clk     (clk),
    .ctl     (ctl),
    .seg     (seg_r[CH_BLUE]),
    .level_r (out_ch.blue_level)
  );

  // An accepted index always occupies the first stage in the next cycle.
  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[STG_SEL])
    else $error("accepted index did not enter the pipeline");

  // A full first stage whose successor has room moves forward.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[STG_SEL] && rdy[STG_MUL]) |=> vld_r[STG_MUL])
    else $error("first stage word was not passed on");

  // Words in flight change only by accepted inputs and delivered outputs.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ($countones(vld_r) ==
               $past($countones(vld_r)) + $past(32'(in_fire)) - $past(32'(out_fire))))
    else $error("pipeline lost or duplicated a word");

endmodule
